FILE: rtl/core/gscm_pkg.sv
// shared types and constants for the grid segment cell marker
package gscm_pkg;

  localparam int ACC_W = 68;
  localparam int OPB_W = 34;
  localparam int REM_W = 37;
  localparam int ALU_W = 38;
  localparam int ITER_W = 7;

  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  localparam logic [ITER_W-1:0] ITER_MUL   = 7'd34;
  localparam logic [ITER_W-1:0] ITER_SQRT  = 7'd34;
  localparam logic [ITER_W-1:0] ITER_LOC   = 7'd33;
  localparam logic [ITER_W-1:0] ITER_ALONG = 7'd68;

  // ceil(2^35 / 10): floor(x / 10) = (x * STEP_RECIP) >> 35 for x below 2^32
  localparam logic [OPB_W-1:0] STEP_RECIP = 34'h0_CCCC_CCCD;

  localparam logic [1:0] MODE_MARK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [1:0] REG_GRID_MIN_X  = 2'd0;
  localparam logic [1:0] REG_GRID_MIN_Y  = 2'd1;
  localparam logic [1:0] REG_CELL_SIZE_X = 2'd2;
  localparam logic [1:0] REG_CELL_SIZE_Y = 2'd3;

  localparam logic [1:0] STATUS_INTERSECTING = 2'd1;

  typedef struct packed {
    logic              go;
    logic [1:0]        op;
    logic [ITER_W-1:0] nbits;
  } arith_req_t;

endpackage

FILE: rtl/core/gscm_arith.sv
// shared iterative multiply, divide and square root unit
module gscm_arith (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gscm_pkg::arith_req_t                req,
  input  logic [gscm_pkg::ACC_W-1:0]          opa,
  input  logic [gscm_pkg::OPB_W-1:0]          opb,
  output logic                                busy,
  output logic                                done,
  output logic [gscm_pkg::ACC_W-1:0]          res
);

  logic                              run_r;
  logic                              done_r;
  logic [gscm_pkg::ITER_W-1:0]       cnt_r;
  logic [1:0]                        op_r;
  logic [gscm_pkg::ACC_W-1:0]        acc_r;
  logic [gscm_pkg::REM_W-1:0]        rem_r;
  logic [gscm_pkg::OPB_W-1:0]        root_r;
  logic [gscm_pkg::OPB_W-1:0]        opb_r;

  logic [gscm_pkg::REM_W-1:0]        alu_a;
  logic [gscm_pkg::REM_W-1:0]        alu_b;
  logic                              alu_sub;
  logic [gscm_pkg::ALU_W-1:0]        alu_res;
  logic                              borrow;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (op_r)
      gscm_pkg::OP_MUL: begin
        alu_a = {3'b000, acc_r[67:34]};
        alu_b = acc_r[0] ? {3'b000, opb_r} : '0;
      end
      gscm_pkg::OP_DIV: begin
        alu_a   = {rem_r[35:0], acc_r[67]};
        alu_b   = {3'b000, opb_r};
        alu_sub = 1'b1;
      end
      gscm_pkg::OP_SQRT: begin
        alu_a   = {rem_r[34:0], acc_r[67:66]};
        alu_b   = {1'b0, root_r, 2'b01};
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
    alu_res = {1'b0, alu_a} + ({1'b0, alu_b} ^ {gscm_pkg::ALU_W{alu_sub}})
              + gscm_pkg::ALU_W'(alu_sub);
    borrow  = alu_res[37];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= gscm_pkg::OP_MUL;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        run_r  <= 1'b1;
        cnt_r  <= req.nbits;
        op_r   <= req.op;
        acc_r  <= opa;
        opb_r  <= opb;
        rem_r  <= '0;
        root_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
        case (op_r)
          gscm_pkg::OP_MUL: begin
            acc_r <= {alu_res[34:0], acc_r[33:1]};
          end
          gscm_pkg::OP_DIV: begin
            rem_r <= borrow ? alu_a : alu_res[36:0];
            acc_r <= {acc_r[66:0], ~borrow};
          end
          gscm_pkg::OP_SQRT: begin
            rem_r  <= borrow ? alu_a : alu_res[36:0];
            root_r <= {root_r[32:0], ~borrow};
            acc_r  <= {acc_r[65:0], 2'b00};
          end
          default: begin
            acc_r <= acc_r;
          end
        endcase
      end
    end
  end

  assign busy = run_r;
  assign done = done_r;
  assign res  = (op_r == gscm_pkg::OP_SQRT) ? {34'b0, root_r} : acc_r;

endmodule

FILE: rtl/core/gscm_grid.sv
// cell status memory with clearing pass after reset
module gscm_grid #(
  parameter int CELLS = 16384,
  parameter int AW    = 14
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [1:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [1:0]    rd_data,
  output logic          clearing
);

  logic [1:0]    mem [CELLS];
  logic          clr_r;
  logic [AW-1:0] clr_idx_r;
  logic [1:0]    rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
    end else if (clr_r) begin
      clr_idx_r <= clr_idx_r + AW'(1);
      if (clr_idx_r == AW'(CELLS - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_idx_r] <= 2'b00;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data  = rd_data_r;
  assign clearing = clr_r;

endmodule

FILE: rtl/core/grid_segment_cell_marker.sv
// top level: segment cell marker sequencer over a square status grid
// modes 1 to 3 finish without the arithmetic unit; mode 0 runs its setup,
// each sample and the end cell through the shared bit-serial multiply / divide /
// square root unit
// one request at a time; busy stays high until the result strobe
// after reset the grid clearing pass holds busy until every grid cell is cleared
module grid_segment_cell_marker #(
  parameter int GRID_SPAN   = 128,
  parameter int MAX_SAMPLES = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [31:0] in_end_x,
  input  logic signed [31:0] in_end_y,
  input  logic [6:0]         in_cell_col,
  input  logic [6:0]         in_cell_row,
  input  logic [1:0]         in_status_in,
  output logic               out_valid,
  output logic [1:0]         out_status_out,
  output logic               out_start_in_grid,
  output logic               out_end_marked,
  output logic [12:0]        out_samples_taken,
  output logic               out_sample_overflow,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int IDXW  = (GRID_SPAN > 1) ? $clog2(GRID_SPAN) : 1;
  localparam int CELLS = GRID_SPAN * GRID_SPAN;
  localparam int AW    = $clog2(CELLS);
  localparam int CNTW  = $clog2(MAX_SAMPLES + 1);

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_RD      = 5'd1;
  localparam logic [4:0] ST_LOC0    = 5'd2;
  localparam logic [4:0] ST_LOC1    = 5'd3;
  localparam logic [4:0] ST_LOC2    = 5'd4;
  localparam logic [4:0] ST_WAIT    = 5'd5;
  localparam logic [4:0] ST_START   = 5'd6;
  localparam logic [4:0] ST_CSX2    = 5'd7;
  localparam logic [4:0] ST_CSY2    = 5'd8;
  localparam logic [4:0] ST_ROOT    = 5'd9;
  localparam logic [4:0] ST_STEP    = 5'd10;
  localparam logic [4:0] ST_MX2     = 5'd11;
  localparam logic [4:0] ST_MY2     = 5'd12;
  localparam logic [4:0] ST_LEN     = 5'd13;
  localparam logic [4:0] ST_SMP0    = 5'd14;
  localparam logic [4:0] ST_SMP1    = 5'd15;
  localparam logic [4:0] ST_SMP2    = 5'd16;
  localparam logic [4:0] ST_SMP2B   = 5'd17;
  localparam logic [4:0] ST_SMP2C   = 5'd18;
  localparam logic [4:0] ST_SMP3    = 5'd19;
  localparam logic [4:0] ST_END0    = 5'd20;
  localparam logic [4:0] ST_END1    = 5'd21;
  localparam logic [4:0] ST_FIN     = 5'd22;

  // configuration
  logic signed [31:0] gmx_r;
  logic signed [31:0] gmy_r;
  logic [30:0]        csx_r;
  logic [30:0]        csy_r;
  logic [30:0]        csx_eff;
  logic [30:0]        csy_eff;

  // sequencer
  logic [4:0]         st_r;
  logic [4:0]         ret_r;
  logic [4:0]         lret_r;
  logic               accept;
  logic               clearing;

  // request
  logic signed [31:0] sx_r;
  logic signed [31:0] sy_r;
  logic signed [31:0] ex_r;
  logic signed [31:0] ey_r;
  logic               dxneg_r;
  logic               dyneg_r;
  logic [32:0]        magx_r;
  logic [32:0]        magy_r;
  logic               rdok_r;

  // working values
  logic signed [33:0] px_r;
  logic signed [33:0] py_r;
  logic [33:0]        qx_r;
  logic               loc_ok_r;
  logic [IDXW-1:0]    col_r;
  logic [IDXW-1:0]    row_r;
  logic [67:0]        p1_r;
  logic [33:0]        step_r;
  logic [33:0]        len_r;
  logic [33:0]        draw_r;
  logic [33:0]        d_r;

  // results
  logic               out_valid_r;
  logic [1:0]         stat_r;
  logic               start_ok_r;
  logic               end_ok_r;
  logic [CNTW-1:0]    cnt_r;
  logic               ovf_r;
  logic [CNTW+12:0]   cnt_ext;

  // arithmetic unit
  gscm_pkg::arith_req_t req;
  logic [67:0]        opa;
  logic [33:0]        opb;
  logic               arith_busy;
  logic               arith_done;
  logic [67:0]        res;

  // grid memory
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [1:0]         wr_data;
  logic [AW-1:0]      rd_addr;
  logic [1:0]         rd_data;
  logic [AW-1:0]      port_addr;
  logic [AW-1:0]      mark_addr;
  logic [IDXW-1:0]    pcol;
  logic [IDXW-1:0]    prow;
  logic               port_ok;
  logic               mark_en;

  // combinational helpers
  logic               loc_in;
  logic [34:0]        ux;
  logic [34:0]        uy;
  logic [33:0]        dsel;
  logic [34:0]        dnext;
  logic signed [33:0] sx34;
  logic signed [33:0] sy34;
  logic [32:0]        dx33;
  logic [32:0]        dy33;
  logic [IDXW-1:0]    qx_idx;
  logic [IDXW-1:0]    qy_idx;

  assign csx_eff = (csx_r == 31'd0) ? 31'd1 : csx_r;
  assign csy_eff = (csy_r == 31'd0) ? 31'd1 : csy_r;

  assign busy   = (st_r != ST_IDLE) || clearing;
  assign accept = start && !busy;

  assign loc_in = (px_r >= 34'(gmx_r)) && (py_r >= 34'(gmy_r));
  assign ux     = {px_r[33], px_r} - 35'(gmx_r);
  assign uy     = {py_r[33], py_r} - 35'(gmy_r);
  assign dsel   = (draw_r > len_r) ? len_r : draw_r;
  assign dnext  = {1'b0, draw_r} + {1'b0, step_r};
  assign sx34   = 34'(sx_r);
  assign sy34   = 34'(sy_r);
  assign dx33   = {in_end_x[31], in_end_x} - {in_start_x[31], in_start_x};
  assign dy33   = {in_end_y[31], in_end_y} - {in_start_y[31], in_start_y};
  assign qx_idx = (qx_r == 34'(GRID_SPAN)) ? IDXW'(GRID_SPAN - 1) : qx_r[IDXW-1:0];
  assign qy_idx = (res[33:0] == 34'(GRID_SPAN)) ? IDXW'(GRID_SPAN - 1) : res[IDXW-1:0];

  assign pcol      = IDXW'(in_cell_col);
  assign prow      = IDXW'(in_cell_row);
  assign port_ok   = (32'(in_cell_col) < 32'(GRID_SPAN)) && (32'(in_cell_row) < 32'(GRID_SPAN));
  assign port_addr = AW'(pcol) * AW'(GRID_SPAN) + AW'(prow);
  assign mark_addr = AW'(col_r) * AW'(GRID_SPAN) + AW'(row_r);
  assign mark_en   = loc_ok_r && ((st_r == ST_START) || (st_r == ST_SMP3) || (st_r == ST_END1));

  always_comb begin
    if (st_r == ST_IDLE) begin
      wr_en   = accept && (in_mode == gscm_pkg::MODE_WRITE) && port_ok;
      wr_addr = port_addr;
      wr_data = in_status_in;
    end else begin
      wr_en   = mark_en;
      wr_addr = mark_addr;
      wr_data = gscm_pkg::STATUS_INTERSECTING;
    end
    rd_addr = port_addr;
  end

  // operand selection for the shared unit
  always_comb begin
    req = '0;
    opa = '0;
    opb = '0;
    case (st_r)
      ST_LOC0: begin
        if (loc_in) begin
          req.go    = 1'b1;
          req.op    = gscm_pkg::OP_DIV;
          req.nbits = gscm_pkg::ITER_LOC;
          opa       = {ux[32:0], 35'b0};
          opb       = {3'b000, csx_eff};
        end
      end
      ST_LOC1: begin
        req.go    = 1'b1;
        req.op    = gscm_pkg::OP_DIV;
        req.nbits = gscm_pkg::ITER_LOC;
        opa       = {uy[32:0], 35'b0};
        opb       = {3'b000, csy_eff};
      end
      ST_START: begin
        if (loc_ok_r) begin
          req.go    = 1'b1;
          req.op    = gscm_pkg::OP_MUL;
          req.nbits = gscm_pkg::ITER_MUL;
          opa       = {37'b0, csx_eff};
          opb       = {3'b000, csx_eff};
        end
      end
      ST_CSX2: begin
        req.go    = 1'b1;
        req.op    = gscm_pkg::OP_MUL;
        req.nbits = gscm_pkg::ITER_MUL;
        opa       = {37'b0, csy_eff};
        opb       = {3'b000, csy_eff};
      end
      ST_CSY2, ST_MY2: begin
        req.go    = 1'b1;
        req.op    = gscm_pkg::OP_SQRT;
        req.nbits = gscm_pkg::ITER_SQRT;
        opa       = p1_r + res;
      end
      ST_ROOT: begin
        // divide by ten through the reciprocal product
        req.go    = 1'b1;
        req.op    = gscm_pkg::OP_MUL;
        req.nbits = gscm_pkg::ITER_MUL;
        opa       = {34'b0, res[33:0]};
        opb       = gscm_pkg::STEP_RECIP;
      end
      ST_STEP: begin
        req.go    = 1'b1;
        req.op    = gscm_pkg::OP_MUL;
        req.nbits = gscm_pkg::ITER_MUL;
        opa       = {35'b0, magx_r};
        opb       = {1'b0, magx_r};
      end
      ST_MX2: begin
        req.go    = 1'b1;
        req.op    = gscm_pkg::OP_MUL;
        req.nbits = gscm_pkg::ITER_MUL;
        opa       = {35'b0, magy_r};
        opb       = {1'b0, magy_r};
      end
      ST_SMP0: begin
        if (len_r != 34'd0) begin
          req.go    = 1'b1;
          req.op    = gscm_pkg::OP_MUL;
          req.nbits = gscm_pkg::ITER_MUL;
          opa       = {35'b0, magx_r};
          opb       = dsel;
        end
      end
      ST_SMP1, ST_SMP2B: begin
        req.go    = 1'b1;
        req.op    = gscm_pkg::OP_DIV;
        req.nbits = gscm_pkg::ITER_ALONG;
        opa       = res;
        opb       = len_r;
      end
      ST_SMP2: begin
        req.go    = 1'b1;
        req.op    = gscm_pkg::OP_MUL;
        req.nbits = gscm_pkg::ITER_MUL;
        opa       = {35'b0, magy_r};
        opb       = d_r;
      end
      default: begin
        req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gmx_r <= '0;
      gmy_r <= '0;
      csx_r <= 31'd65536;
      csy_r <= 31'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gscm_pkg::REG_GRID_MIN_X:  gmx_r <= cfg_wdata;
        gscm_pkg::REG_GRID_MIN_Y:  gmy_r <= cfg_wdata;
        gscm_pkg::REG_CELL_SIZE_X: csx_r <= cfg_wdata[30:0];
        gscm_pkg::REG_CELL_SIZE_Y: csy_r <= cfg_wdata[30:0];
        default: gmx_r <= gmx_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      ret_r       <= ST_IDLE;
      lret_r      <= ST_IDLE;
      out_valid_r <= 1'b0;
      stat_r      <= '0;
      start_ok_r  <= 1'b0;
      end_ok_r    <= 1'b0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      loc_ok_r    <= 1'b0;
    end else begin
      out_valid_r <= (st_r == ST_FIN);
      case (st_r)
        ST_IDLE: begin
          if (accept) begin
            sx_r       <= in_start_x;
            sy_r       <= in_start_y;
            ex_r       <= in_end_x;
            ey_r       <= in_end_y;
            dxneg_r    <= dx33[32];
            dyneg_r    <= dy33[32];
            magx_r     <= dx33[32] ? (33'd0 - dx33) : dx33;
            magy_r     <= dy33[32] ? (33'd0 - dy33) : dy33;
            rdok_r     <= port_ok;
            stat_r     <= '0;
            start_ok_r <= 1'b0;
            end_ok_r   <= 1'b0;
            cnt_r      <= '0;
            ovf_r      <= 1'b0;
            case (in_mode)
              gscm_pkg::MODE_MARK: begin
                px_r   <= 34'(in_start_x);
                py_r   <= 34'(in_start_y);
                lret_r <= ST_START;
                st_r   <= ST_LOC0;
              end
              gscm_pkg::MODE_READ: st_r <= ST_RD;
              default: st_r <= ST_FIN;
            endcase
          end
        end
        ST_RD: begin
          stat_r <= rdok_r ? rd_data : 2'b00;
          st_r   <= ST_FIN;
        end
        ST_WAIT: begin
          if (arith_done) begin
            st_r <= ret_r;
          end
        end
        ST_LOC0: begin
          if (loc_in) begin
            ret_r <= ST_LOC1;
            st_r  <= ST_WAIT;
          end else begin
            loc_ok_r <= 1'b0;
            st_r     <= lret_r;
          end
        end
        ST_LOC1: begin
          qx_r  <= res[33:0];
          ret_r <= ST_LOC2;
          st_r  <= ST_WAIT;
        end
        ST_LOC2: begin
          loc_ok_r <= (qx_r <= 34'(GRID_SPAN)) && (res[33:0] <= 34'(GRID_SPAN));
          col_r    <= qx_idx;
          row_r    <= qy_idx;
          st_r     <= lret_r;
        end
        ST_START: begin
          if (loc_ok_r) begin
            start_ok_r <= 1'b1;
            ret_r      <= ST_CSX2;
            st_r       <= ST_WAIT;
          end else begin
            st_r <= ST_FIN;
          end
        end
        ST_CSX2: begin
          p1_r  <= res;
          ret_r <= ST_CSY2;
          st_r  <= ST_WAIT;
        end
        ST_CSY2: begin
          ret_r <= ST_ROOT;
          st_r  <= ST_WAIT;
        end
        ST_ROOT: begin
          ret_r <= ST_STEP;
          st_r  <= ST_WAIT;
        end
        ST_STEP: begin
          step_r <= (res[67:35] == 33'd0) ? 34'd1 : {1'b0, res[67:35]};
          ret_r  <= ST_MX2;
          st_r   <= ST_WAIT;
        end
        ST_MX2: begin
          p1_r  <= res;
          ret_r <= ST_MY2;
          st_r  <= ST_WAIT;
        end
        ST_MY2: begin
          ret_r <= ST_LEN;
          st_r  <= ST_WAIT;
        end
        ST_LEN: begin
          len_r  <= res[33:0];
          draw_r <= step_r;
          st_r   <= ST_SMP0;
        end
        ST_SMP0: begin
          d_r <= dsel;
          if (len_r == 34'd0) begin
            px_r   <= sx34;
            py_r   <= sy34;
            lret_r <= ST_SMP3;
            st_r   <= ST_LOC0;
          end else begin
            ret_r <= ST_SMP1;
            st_r  <= ST_WAIT;
          end
        end
        ST_SMP1: begin
          ret_r <= ST_SMP2;
          st_r  <= ST_WAIT;
        end
        ST_SMP2: begin
          px_r  <= dxneg_r ? (sx34 - $signed(res[33:0])) : (sx34 + $signed(res[33:0]));
          ret_r <= ST_SMP2B;
          st_r  <= ST_WAIT;
        end
        ST_SMP2B: begin
          ret_r <= ST_SMP2C;
          st_r  <= ST_WAIT;
        end
        ST_SMP2C: begin
          py_r   <= dyneg_r ? (sy34 - $signed(res[33:0])) : (sy34 + $signed(res[33:0]));
          lret_r <= ST_SMP3;
          st_r   <= ST_LOC0;
        end
        ST_SMP3: begin
          if (!loc_ok_r) begin
            st_r <= ST_FIN;
          end else begin
            cnt_r <= cnt_r + CNTW'(1);
            if (!(dnext < {1'b0, len_r})) begin
              st_r <= ST_END0;
            end else if (cnt_r == CNTW'(MAX_SAMPLES - 1)) begin
              ovf_r <= 1'b1;
              st_r  <= ST_END0;
            end else begin
              draw_r <= dnext[33:0];
              st_r   <= ST_SMP0;
            end
          end
        end
        ST_END0: begin
          px_r   <= 34'(ex_r);
          py_r   <= 34'(ey_r);
          lret_r <= ST_END1;
          st_r   <= ST_LOC0;
        end
        ST_END1: begin
          if (loc_ok_r) begin
            end_ok_r <= 1'b1;
          end
          st_r <= ST_FIN;
        end
        ST_FIN: begin
          st_r <= ST_IDLE;
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  gscm_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .opa   (opa),
    .opb   (opb),
    .busy  (arith_busy),
    .done  (arith_done),
    .res   (res)
  );

  gscm_grid #(
    .CELLS (CELLS),
    .AW    (AW)
  ) u_grid (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  assign cnt_ext = {13'b0, cnt_r};

  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_status_out      = stat_r;
  assign out_start_in_grid   = start_ok_r;
  assign out_end_marked      = end_ok_r;
  assign out_samples_taken   = cnt_ext[12:0];
  assign out_sample_overflow = ovf_r;

  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.go |-> !arith_busy)
    else $error("arith request while unit running");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_wait_live: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_WAIT) |-> (arith_busy || arith_done))
    else $error("waiting on idle arith unit");

  a_start_gates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_start_in_grid) |-> (!out_end_marked && !out_sample_overflow))
    else $error("segment flags set without start cell");

endmodule
